FILE: design/tlt_pkg.sv
// Shared types, constants and a helper function of the trace line tokenizer.
package tlt_pkg;

    localparam int MAX_FIELDS = 16;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 5;

    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_VTAB    = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FEED    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_RETURN  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;

    localparam logic [WORD_W-1:0] FIELD_LIMIT = WORD_W'(MAX_FIELDS);

    typedef enum logic [2:0] {
        ROLE_SKIP    = 3'd0,
        ROLE_START   = 3'd1,
        ROLE_QUOTE   = 3'd2,
        ROLE_CONTENT = 3'd3,
        ROLE_END     = 3'd4
    } t_role;

    typedef struct packed {
        logic              inside_word;
        logic              inside_string;
        logic              inside_comment;
        logic [WORD_W-1:0] words_seen;
        logic [WORD_W-1:0] open_index;
        logic              open_kept;
    } t_tok_state;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        t_role             role;
        logic [WORD_W-1:0] word_index;
        logic              word_kept;
        logic              line_end;
        logic [WORD_W-1:0] line_words;
    } t_tok_result;

    localparam t_tok_state STATE_RESET = '0;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE) ||
               (c == CHAR_VTAB) || (c == CHAR_FEED) || (c == CHAR_RETURN);
    endfunction

endpackage

FILE: design/tlt_step.sv
// Combinational classification of one byte and the tokenizer state update.
module tlt_step (
    input  tlt_pkg::t_tok_state              i_state,
    input  logic [tlt_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_buffer_end,
    output tlt_pkg::t_tok_state              o_state,
    output tlt_pkg::t_tok_result             o_result
);

    tlt_pkg::t_tok_state  st;
    tlt_pkg::t_tok_result res;
    logic                 line_break;
    logic                 blank;

    assign line_break = (i_data_byte == tlt_pkg::CHAR_NEWLINE) ||
                        (i_data_byte == tlt_pkg::CHAR_NUL);
    assign blank      = tlt_pkg::is_blank(i_data_byte);

    always_comb begin
        st             = i_state;
        res            = '0;
        res.byte_out   = i_data_byte;
        res.role       = tlt_pkg::ROLE_SKIP;
        res.line_end   = i_buffer_end;

        priority if (i_state.inside_comment) begin
            if (line_break) begin
                res.line_end = 1'b1;
            end
        end else if (line_break) begin
            if (i_state.inside_word || i_state.inside_string) begin
                res.role       = tlt_pkg::ROLE_END;
                res.word_index = i_state.open_index;
                res.word_kept  = i_state.open_kept;
            end
            st.inside_word   = 1'b0;
            st.inside_string = 1'b0;
            res.line_end     = 1'b1;
        end else if (i_state.inside_string) begin
            res.word_index = i_state.open_index;
            res.word_kept  = i_state.open_kept;
            if (i_data_byte == tlt_pkg::CHAR_QUOTE) begin
                res.role         = tlt_pkg::ROLE_END;
                st.inside_string = 1'b0;
            end else begin
                res.role = tlt_pkg::ROLE_CONTENT;
            end
        end else if (i_data_byte == tlt_pkg::CHAR_HASH) begin
            if (i_state.inside_word) begin
                res.role       = tlt_pkg::ROLE_END;
                res.word_index = i_state.open_index;
                res.word_kept  = i_state.open_kept;
            end
            st.inside_word    = 1'b0;
            st.inside_comment = 1'b1;
        end else if (i_state.inside_word) begin
            res.word_index = i_state.open_index;
            res.word_kept  = i_state.open_kept;
            if (blank) begin
                res.role       = tlt_pkg::ROLE_END;
                st.inside_word = 1'b0;
            end else begin
                res.role = tlt_pkg::ROLE_CONTENT;
            end
        end else if (!blank) begin
            if (i_data_byte == tlt_pkg::CHAR_QUOTE) begin
                res.role         = tlt_pkg::ROLE_QUOTE;
                st.inside_string = 1'b1;
            end else begin
                res.role       = tlt_pkg::ROLE_START;
                st.inside_word = 1'b1;
            end
            if (i_state.words_seen < tlt_pkg::FIELD_LIMIT) begin
                st.open_index = i_state.words_seen;
                st.open_kept  = 1'b1;
                st.words_seen = i_state.words_seen + 1'b1;
            end else begin
                st.open_index = tlt_pkg::FIELD_LIMIT;
                st.open_kept  = 1'b0;
            end
            res.word_index = st.open_index;
            res.word_kept  = st.open_kept;
        end else begin
            res.role = tlt_pkg::ROLE_SKIP;
        end

        if (res.line_end) begin
            res.line_words = st.words_seen;
            st             = tlt_pkg::STATE_RESET;
        end
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

FILE: design/trace_line_tokenizer_unit.sv
// Top level of the trace line tokenizer: input register, byte classifier and result register.
// The unit takes one byte of trace text per cycle while the consumer keeps ready high and
// returns one result per byte, in order. A byte is captured in the input register, classified
// against the line state, and the result is presented from the output register, so throughput
// is one byte per clock whenever the consumer keeps ready high. The line state (open word,
// open string, comment, word count) is advanced as each byte moves into the output register
// and returns to its reset values after every line end.
module trace_line_tokenizer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tlt_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_buffer_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tlt_pkg::BYTE_W-1:0]   o_byte_out,
    output logic [2:0]                   o_role,
    output logic [tlt_pkg::WORD_W-1:0]   o_word_index,
    output logic                         o_word_kept,
    output logic                         o_line_end,
    output logic [tlt_pkg::WORD_W-1:0]   o_line_words
);

    logic                        r_in_valid;
    logic [tlt_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_end;
    logic                        r_out_valid;
    tlt_pkg::t_tok_result        r_out;
    tlt_pkg::t_tok_state         r_state;
    tlt_pkg::t_tok_state         n_state;
    tlt_pkg::t_tok_result        n_out;
    logic                        advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    tlt_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_buffer_end (r_in_end),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= tlt_pkg::STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_buffer_end;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_out.byte_out;
    assign o_role       = r_out.role;
    assign o_word_index = r_out.word_index;
    assign o_word_kept  = r_out.word_kept;
    assign o_line_end   = r_out.line_end;
    assign o_line_words = r_out.line_words;

endmodule
